// ===== design/mips_subset_execute_16bit_core_defines.svh =====
// Assertion macros shared by the execute core.
`ifndef MIPS_SUBSET_EXECUTE_16BIT_CORE_DEFINES_SVH
`define MIPS_SUBSET_EXECUTE_16BIT_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while reset is low.
`define MSX16_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while reset is low.
`define MSX16_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/msx16_pkg.sv =====
`default_nettype none

package msx16_pkg;

    localparam int DATA_W    = 16;
    localparam int NUM_REGS  = 32;
    localparam int REG_IDX_W = 5;
    localparam int REG_AW    = $clog2(NUM_REGS);
    localparam int PC_W      = 10;
    localparam int ACT_W     = 5;
    localparam int ERR_W     = 2;
    localparam int CNT_W     = $clog2(DATA_W);

    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_DIV0  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_SHIFT = 2'd2;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD   = 5'd0,
        ACT_SUB   = 5'd1,
        ACT_SUBU  = 5'd2,
        ACT_AND   = 5'd3,
        ACT_OR    = 5'd4,
        ACT_NOR   = 5'd5,
        ACT_SLT   = 5'd6,
        ACT_SLTU  = 5'd7,
        ACT_SLL   = 5'd8,
        ACT_SRL   = 5'd9,
        ACT_DIV   = 5'd10,
        ACT_DIVU  = 5'd11,
        ACT_MULT  = 5'd12,
        ACT_MULTU = 5'd13,
        ACT_ADDI  = 5'd14,
        ACT_LI    = 5'd15,
        ACT_BEQ   = 5'd16,
        ACT_BNE   = 5'd17,
        ACT_J     = 5'd18,
        ACT_JAL   = 5'd19,
        ACT_JR    = 5'd20
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== design/mips_subset_execute_16bit_core.sv =====
// An accepted input beat is latched, executed in the execute state and held in the done state until the
// output register is free; mult, multu, div and divu first take sixteen passes of the shared adder.
// The core stalls its input until each result has moved into the output register, so it takes no new
// item before the last is through; multiply and divide run a 16-step iteration of the one shared adder/subtractor.
// Reset (synchronous, active low) zeroes the program counter, marks every register as zero
// through its valid bit, and drops any pending result beat; no clearing pass is needed.
`default_nettype none
`include "mips_subset_execute_16bit_core_defines.svh"

module mips_subset_execute_16bit_core
    import msx16_pkg::*;
(
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    // Instruction channel.
    input  wire                       i_valid,
    output logic                      o_stall,
    input  wire  [ACT_W-1:0]          i_action,
    input  wire  [REG_IDX_W-1:0]      i_dest_reg,
    input  wire  [REG_IDX_W-1:0]      i_src_a_reg,
    input  wire  [REG_IDX_W-1:0]      i_src_b_reg,
    input  wire  signed [DATA_W-1:0]  i_immediate,
    input  wire  [PC_W-1:0]           i_target,
    // Result channel.
    output logic                      o_valid,
    input  wire                       i_stall,
    output logic [PC_W-1:0]           o_next_pc,
    output logic                      o_write_enable,
    output logic [REG_IDX_W-1:0]      o_written_reg,
    output logic signed [DATA_W-1:0]  o_written_value,
    output logic [ERR_W-1:0]          o_error_code
);

    localparam logic [REG_IDX_W-1:0] LINK_REG = REG_IDX_W'(NUM_REGS - 1);
    localparam logic [CNT_W-1:0]     CNT_LAST = CNT_W'(DATA_W - 1);

    // Sequencer state and the latched instruction.
    t_state                r_state, n_state;
    t_action               r_action, n_action;
    logic [REG_IDX_W-1:0]  r_dest, n_dest;
    logic [DATA_W-1:0]     r_imm, n_imm;
    logic [PC_W-1:0]       r_target, n_target;
    logic [PC_W-1:0]       r_pc, n_pc;

    // Register file: a memory with registered read ports and one valid bit per entry,
    // so an entry never written since reset reads as zero.
    logic [DATA_W-1:0]     r_regs [NUM_REGS];
    logic [NUM_REGS-1:0]   r_reg_valid;
    logic [DATA_W-1:0]     r_a_mem, r_b_mem;
    logic                  r_a_ok, r_b_ok;
    logic [DATA_W-1:0]     opa, opb;

    // Iteration registers. For divide r_rem is the partial remainder, r_quo the dividend
    // that turns into the quotient and r_dvs the divisor. For multiply r_rem accumulates,
    // r_dvs is the multiplicand shifted left and r_quo the multiplier shifted right.
    logic [DATA_W-1:0]     r_rem, n_rem;
    logic [DATA_W-1:0]     r_quo, n_quo;
    logic [DATA_W-1:0]     r_dvs, n_dvs;
    logic                  r_neg, n_neg;
    logic [CNT_W-1:0]      r_cnt, n_cnt;

    // Finished result, waiting for the output register to free up.
    logic [PC_W-1:0]       r_res_pc, n_res_pc;
    logic                  r_res_wr, n_res_wr;
    logic [REG_IDX_W-1:0]  r_res_reg, n_res_reg;
    logic [DATA_W-1:0]     r_res_val, n_res_val;
    logic [ERR_W-1:0]      r_res_err, n_res_err;

    // Output register.
    logic                  r_out_valid, n_out_valid;
    logic [PC_W-1:0]       r_out_pc, n_out_pc;
    logic                  r_out_we, n_out_we;
    logic [REG_IDX_W-1:0]  r_out_reg, n_out_reg;
    logic [DATA_W-1:0]     r_out_val, n_out_val;
    logic [ERR_W-1:0]      r_out_err, n_out_err;

    // The shared adder/subtractor, 17 bits so that its top bit is a borrow or a sign.
    logic [DATA_W:0]       add_x, add_y, add_sum;
    logic                  add_sub;

    logic                  accept;
    logic                  out_free;
    logic                  commit;
    logic [PC_W-1:0]       seq_pc;
    logic [DATA_W-1:0]     quo_step;
    logic                  div_ok;
    logic                  wr;
    logic [REG_IDX_W-1:0]  wreg;

    assign o_stall  = (r_state != ST_IDLE);
    assign accept   = i_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_stall;
    assign commit   = (r_state == ST_DONE) && out_free;
    assign seq_pc   = r_pc + PC_W'(1);

    assign opa = r_a_ok ? r_a_mem : '0;
    assign opb = r_b_ok ? r_b_mem : '0;

    assign add_sum = add_sub ? (add_x - add_y) : (add_x + add_y);

    // Divide step: a clear borrow means the shifted remainder covers the divisor.
    assign div_ok   = !add_sum[DATA_W];
    assign quo_step = {r_quo[DATA_W-2:0], div_ok};

    // Operand selection for the shared adder.
    always_comb begin
        add_x   = {1'b0, opa};
        add_y   = {1'b0, opb};
        add_sub = 1'b0;
        case (r_state)
            ST_EXEC: begin
                case (r_action) inside
                    ACT_SUB, ACT_SUBU, ACT_SLTU: begin
                        add_sub = 1'b1;
                    end
                    ACT_SLT: begin
                        add_x   = {opa[DATA_W-1], opa};
                        add_y   = {opb[DATA_W-1], opb};
                        add_sub = 1'b1;
                    end
                    ACT_ADDI: begin
                        add_y = {1'b0, r_imm};
                    end
                    default: begin
                        add_sub = 1'b0;
                    end
                endcase
            end
            ST_DIV: begin
                add_x   = {r_rem, r_quo[DATA_W-1]};
                add_y   = {1'b0, r_dvs};
                add_sub = 1'b1;
            end
            ST_MUL: begin
                add_x = {1'b0, r_rem};
                add_y = {1'b0, r_dvs};
            end
            default: begin
                add_sub = 1'b0;
            end
        endcase
    end

    // Next state and datapath.
    always_comb begin
        n_state     = r_state;
        n_action    = r_action;
        n_dest      = r_dest;
        n_imm       = r_imm;
        n_target    = r_target;
        n_pc        = r_pc;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_dvs       = r_dvs;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_res_pc    = r_res_pc;
        n_res_wr    = r_res_wr;
        n_res_reg   = r_res_reg;
        n_res_val   = r_res_val;
        n_res_err   = r_res_err;
        n_out_valid = r_out_valid && i_stall;
        n_out_pc    = r_out_pc;
        n_out_we    = r_out_we;
        n_out_reg   = r_out_reg;
        n_out_val   = r_out_val;
        n_out_err   = r_out_err;
        wr          = 1'b0;
        wreg        = r_dest;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_action = t_action'(i_action);
                    n_dest   = i_dest_reg;
                    n_imm    = i_immediate;
                    n_target = i_target;
                    n_state  = ST_EXEC;
                end
            end

            ST_EXEC: begin
                n_res_pc  = seq_pc;
                n_res_val = '0;
                n_res_err = ERR_NONE;
                n_state   = ST_DONE;
                case (r_action)
                    ACT_ADD, ACT_SUB, ACT_SUBU, ACT_ADDI: begin
                        n_res_val = add_sum[DATA_W-1:0];
                        wr        = 1'b1;
                    end
                    ACT_AND: begin
                        n_res_val = opa & opb;
                        wr        = 1'b1;
                    end
                    ACT_OR: begin
                        n_res_val = opa | opb;
                        wr        = 1'b1;
                    end
                    ACT_NOR: begin
                        n_res_val = ~(opa | opb);
                        wr        = 1'b1;
                    end
                    ACT_SLT, ACT_SLTU: begin
                        n_res_val = DATA_W'(add_sum[DATA_W]);
                        wr        = 1'b1;
                    end
                    ACT_SLL, ACT_SRL: begin
                        if (r_imm[DATA_W-1]) begin
                            n_res_err = ERR_SHIFT;
                        end else begin
                            wr = 1'b1;
                            // Any amount of a full word or more clears the value.
                            if (r_imm[DATA_W-1:CNT_W] != '0) begin
                                n_res_val = '0;
                            end else if (r_action == ACT_SLL) begin
                                n_res_val = opa << r_imm[CNT_W-1:0];
                            end else begin
                                n_res_val = opa >> r_imm[CNT_W-1:0];
                            end
                        end
                    end
                    ACT_DIV, ACT_DIVU: begin
                        if (opb == '0) begin
                            n_res_err = ERR_DIV0;
                        end else begin
                            wr      = 1'b1;
                            n_rem   = '0;
                            n_cnt   = '0;
                            n_state = ST_DIV;
                            if (r_action == ACT_DIV) begin
                                // Divide magnitudes, then fix the sign of the quotient.
                                n_neg = opa[DATA_W-1] ^ opb[DATA_W-1];
                                n_quo = opa[DATA_W-1] ? (~opa + DATA_W'(1)) : opa;
                                n_dvs = opb[DATA_W-1] ? (~opb + DATA_W'(1)) : opb;
                            end else begin
                                n_neg = 1'b0;
                                n_quo = opa;
                                n_dvs = opb;
                            end
                        end
                    end
                    ACT_MULT, ACT_MULTU: begin
                        wr      = 1'b1;
                        n_rem   = '0;
                        n_dvs   = opa;
                        n_quo   = opb;
                        n_cnt   = '0;
                        n_state = ST_MUL;
                    end
                    ACT_LI: begin
                        n_res_val = r_imm;
                        wr        = 1'b1;
                    end
                    ACT_BEQ: begin
                        if (opa == opb) begin
                            n_res_pc = r_target;
                        end
                    end
                    ACT_BNE: begin
                        if (opa != opb) begin
                            n_res_pc = r_target;
                        end
                    end
                    ACT_J: begin
                        n_res_pc = r_target;
                    end
                    ACT_JAL: begin
                        wreg      = LINK_REG;
                        n_res_val = DATA_W'(seq_pc);
                        n_res_pc  = r_target;
                        wr        = 1'b1;
                    end
                    ACT_JR: begin
                        n_res_pc = opa[PC_W-1:0];
                    end
                    default: begin
                        n_res_pc = seq_pc;
                    end
                endcase
                // An error holds the counter and cancels the write.
                if (n_res_err != ERR_NONE) begin
                    n_res_pc = r_pc;
                    wr       = 1'b0;
                end
                n_res_reg = wreg;
                n_res_wr  = wr && ({1'b0, wreg} < (REG_IDX_W + 1)'(NUM_REGS));
            end

            ST_DIV: begin
                n_rem = div_ok ? add_sum[DATA_W-1:0] : add_x[DATA_W-1:0];
                n_quo = quo_step;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    n_res_val = r_neg ? (~quo_step + DATA_W'(1)) : quo_step;
                    n_state   = ST_DONE;
                end
            end

            ST_MUL: begin
                if (r_quo[0]) begin
                    n_rem = add_sum[DATA_W-1:0];
                end
                n_dvs = {r_dvs[DATA_W-2:0], 1'b0};
                n_quo = {1'b0, r_quo[DATA_W-1:1]};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    n_res_val = r_quo[0] ? add_sum[DATA_W-1:0] : r_rem;
                    n_state   = ST_DONE;
                end
            end

            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_pc    = r_res_pc;
                    n_out_we    = r_res_wr;
                    n_out_reg   = r_res_wr ? r_res_reg : '0;
                    n_out_val   = r_res_wr ? r_res_val : '0;
                    n_out_err   = r_res_err;
                    n_pc        = r_res_pc;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pc        <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action  <= n_action;
        r_dest    <= n_dest;
        r_imm     <= n_imm;
        r_target  <= n_target;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_dvs     <= n_dvs;
        r_neg     <= n_neg;
        r_res_pc  <= n_res_pc;
        r_res_wr  <= n_res_wr;
        r_res_reg <= n_res_reg;
        r_res_val <= n_res_val;
        r_res_err <= n_res_err;
        r_out_pc  <= n_out_pc;
        r_out_we  <= n_out_we;
        r_out_reg <= n_out_reg;
        r_out_val <= n_out_val;
        r_out_err <= n_out_err;
    end

    // Register file valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_valid <= '0;
        end else if (commit && r_res_wr) begin
            r_reg_valid[r_res_reg[REG_AW-1:0]] <= 1'b1;
        end
    end

    // Register file: operands are read as the instruction is accepted, the result is
    // written as it moves into the output register.
    always_ff @(posedge i_clk) begin
        if (commit && r_res_wr) begin
            r_regs[r_res_reg[REG_AW-1:0]] <= r_res_val;
        end
        if (accept) begin
            r_a_mem <= r_regs[i_src_a_reg[REG_AW-1:0]];
            r_b_mem <= r_regs[i_src_b_reg[REG_AW-1:0]];
            r_a_ok  <= r_reg_valid[i_src_a_reg[REG_AW-1:0]]
                       && ({1'b0, i_src_a_reg} < (REG_IDX_W + 1)'(NUM_REGS));
            r_b_ok  <= r_reg_valid[i_src_b_reg[REG_AW-1:0]]
                       && ({1'b0, i_src_b_reg} < (REG_IDX_W + 1)'(NUM_REGS));
        end
    end

    assign o_valid         = r_out_valid;
    assign o_next_pc       = r_out_pc;
    assign o_write_enable  = r_out_we;
    assign o_written_reg   = r_out_reg;
    assign o_written_value = r_out_val;
    assign o_error_code    = r_out_err;

    // A faulting instruction keeps the counter and never writes a register.
    `MSX16_ASSERT_NOW(a_err_holds_pc, (r_state == ST_DONE) && (r_res_err != ERR_NONE), (r_res_pc == r_pc) && !r_res_wr, "error result moves the counter or writes")
    // The step counter rests at zero whenever the shared unit is not iterating.
    `MSX16_ASSERT_NOW(a_cnt_idle, (r_state != ST_DIV) && (r_state != ST_MUL), r_cnt == '0, "step counter not at zero outside an iteration")
    // An accepted beat always starts execution on the next cycle.
    `MSX16_ASSERT_NEXT(a_accept_exec, accept, r_state == ST_EXEC, "accepted beat did not start execution")
    // A result beat that moves into the output register leaves the core idle.
    `MSX16_ASSERT_NEXT(a_commit_idle, commit, (r_state == ST_IDLE) && r_out_valid, "commit did not present a result beat")

endmodule

`default_nettype wire
